// ===== src/popup_placement_selector_unit_assert.svh =====
// Assertion macros used by the popup placement selector top level.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef POPUP_PLACEMENT_SELECTOR_UNIT_ASSERT_SVH
`define POPUP_PLACEMENT_SELECTOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define PPSU_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("popup placement selector assertion failed");
`define PPSU_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("popup placement selector assertion failed");
`else
`define PPSU_ASSERT(label, prop)
`define PPSU_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== src/ppsu_pkg.sv =====
// Package for the popup placement selector: types, codes and helper functions.
// Used by the front, back and top modules of the block; depends on nothing.
`default_nettype none
package ppsu_pkg;
    localparam int IW = 24;
    typedef logic signed [IW-1:0] coord_t;

    localparam logic [2:0] SIDE_BOTTOM = 3'd0;
    localparam logic [2:0] SIDE_TOP    = 3'd1;
    localparam logic [2:0] SIDE_RIGHT  = 3'd2;
    localparam logic [2:0] SIDE_LEFT   = 3'd3;
    localparam logic [2:0] SIDE_POINT  = 3'd4;

    localparam logic [2:0] REG_VP_X   = 3'd0;
    localparam logic [2:0] REG_VP_Y   = 3'd1;
    localparam logic [2:0] REG_VP_W   = 3'd2;
    localparam logic [2:0] REG_VP_H   = 3'd3;
    localparam logic [2:0] REG_MARGIN = 3'd4;
    localparam logic [2:0] REG_GAP    = 3'd5;
    localparam logic [2:0] REG_MODE   = 3'd6;

    typedef struct packed {
        logic              degen;
        logic [2:0]        mode;
        logic [2:0]        mode_raw;
        coord_t            ax;
        coord_t            ay;
        logic [19:0]       fw;
        logic [19:0]       fh;
        coord_t            minx;
        coord_t            maxx;
        coord_t            miny;
        coord_t            maxy;
        coord_t [3:0]      cand_x;
        coord_t [3:0]      cand_y;
    } ppsu_item_t;

    function automatic logic [1:0] side_order(input logic [1:0] mode, input logic [1:0] k);
        logic [1:0] d;
        case (mode)
            2'd0: d = k;
            2'd1: d = (k == 2'd0) ? 2'd1 : (k == 2'd1) ? 2'd0 : k;
            2'd2: d = k ^ 2'd2;
            default: d = (k == 2'd0) ? 2'd3 : (k == 2'd1) ? 2'd2 : (k == 2'd2) ? 2'd0 : 2'd1;
        endcase
        return d;
    endfunction

    function automatic coord_t clampc(input coord_t v, input coord_t lo, input coord_t hi);
        coord_t r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== src/ppsu_fifo.sv =====
// Small register queue with first-word fall-through read.
// Generic; used between the front and back parts and at the result side.
`default_nettype none
module ppsu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  full,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end
endmodule
`default_nettype wire

// ===== src/ppsu_front.sv =====
// Front part: configuration registers, size clamping, bounds and the four candidates.
// Depends on ppsu_pkg.
`default_nettype none
module ppsu_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [20:0]         cfg_data,
    input  wire logic signed [20:0]  anchor_x,
    input  wire logic signed [20:0]  anchor_y,
    input  wire logic [19:0]         anchor_w,
    input  wire logic [19:0]         anchor_h,
    input  wire logic [19:0]         popup_w,
    input  wire logic [19:0]         popup_h,
    output ppsu_pkg::ppsu_item_t     item,
    output logic [2:0]               mode_cfg
);
    import ppsu_pkg::*;

    logic signed [20:0] vp_x_reg, vp_y_reg;
    logic [19:0]        vp_w_reg, vp_h_reg;
    logic [15:0]        margin_reg;
    logic signed [16:0] gap_reg;
    logic [2:0]         mode_reg;

    logic   valid;
    coord_t vx, vy, vw, vh, m, gap, padw, padh, pw, ph, fw, fh;
    coord_t minx, miny, maxx_raw, maxy_raw, ax, ay, aw, ah;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_x_reg   <= '0;
            vp_y_reg   <= '0;
            vp_w_reg   <= '0;
            vp_h_reg   <= '0;
            margin_reg <= '0;
            gap_reg    <= '0;
            mode_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_VP_X:   vp_x_reg   <= cfg_data;
                REG_VP_Y:   vp_y_reg   <= cfg_data;
                REG_VP_W:   vp_w_reg   <= cfg_data[19:0];
                REG_VP_H:   vp_h_reg   <= cfg_data[19:0];
                REG_MARGIN: margin_reg <= cfg_data[15:0];
                REG_GAP:    gap_reg    <= cfg_data[16:0];
                REG_MODE:   mode_reg   <= cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    assign mode_cfg = mode_reg;

    always_comb
    begin
        valid = (vp_w_reg != '0) && (vp_h_reg != '0);
        vx    = valid ? IW'(vp_x_reg) : '0;
        vy    = valid ? IW'(vp_y_reg) : '0;
        vw    = valid ? IW'(vp_w_reg) : '0;
        vh    = valid ? IW'(vp_h_reg) : '0;
        m     = IW'(margin_reg);
        gap   = IW'(gap_reg);
        ax    = IW'(anchor_x);
        ay    = IW'(anchor_y);
        aw    = IW'(anchor_w);
        ah    = IW'(anchor_h);
        pw    = IW'(popup_w);
        ph    = IW'(popup_h);
        padw  = vw - (m <<< 1);
        padh  = vh - (m <<< 1);
        if (padw < 0)
            padw = '0;
        if (padh < 0)
            padh = '0;
        fw = (pw > padw) ? padw : pw;
        fh = (ph > padh) ? padh : ph;
        minx = vx + m;
        miny = vy + m;
        maxx_raw = vx + vw - m - fw;
        maxy_raw = vy + vh - m - fh;

        item.degen    = !valid || (fw == 0) || (fh == 0);
        item.mode     = (mode_reg > SIDE_POINT) ? SIDE_BOTTOM : mode_reg;
        item.mode_raw = mode_reg;
        item.ax       = ax;
        item.ay       = ay;
        item.fw       = fw[19:0];
        item.fh       = fh[19:0];
        item.minx     = minx;
        item.miny     = miny;
        item.maxx     = (maxx_raw > minx) ? maxx_raw : minx;
        item.maxy     = (maxy_raw > miny) ? maxy_raw : miny;
        item.cand_x[0] = ax;
        item.cand_y[0] = ay + ah + gap;
        item.cand_x[1] = ax;
        item.cand_y[1] = ay - fh - gap;
        item.cand_x[2] = ax + aw + gap;
        item.cand_y[2] = ay;
        item.cand_x[3] = ax - fw - gap;
        item.cand_y[3] = ay;
    end
endmodule
`default_nettype wire

// ===== src/ppsu_back.sv =====
// Back part: fit tests in side order, selection, clamping and coordinate saturation.
// Depends on ppsu_pkg.
`default_nettype none
module ppsu_back #(
    parameter int COORD_BITS = 21,
    parameter int FRAC_BITS  = 16
) (
    input  ppsu_pkg::ppsu_item_t           item,
    output logic signed [COORD_BITS-1:0]   place_x,
    output logic signed [COORD_BITS-1:0]   place_y,
    output logic [19:0]                    fitted_w,
    output logic [19:0]                    fitted_h,
    output logic [2:0]                     chosen_side,
    output logic [FRAC_BITS:0]             visible_share,
    output logic                           was_flipped
);
    import ppsu_pkg::*;

    localparam int SW = (COORD_BITS > IW) ? COORD_BITS : IW;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic [3:0]  fit;
    logic        found;
    logic [1:0]  pick, d;
    coord_t      px, py;
    logic signed [SW-1:0] ex, ey;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (i < 2)
                fit[i] = (item.cand_y[i] >= item.miny) && (item.cand_y[i] <= item.maxy);
            else
                fit[i] = (item.cand_x[i] >= item.minx) && (item.cand_x[i] <= item.maxx);
        end
        found = 1'b0;
        pick  = item.mode[1:0];
        for (int k = 3; k >= 0; k--)
        begin
            d = side_order(item.mode[1:0], 2'(k));
            if (fit[d])
            begin
                found = 1'b1;
                pick  = d;
            end
        end

        px            = clampc(item.cand_x[pick], item.minx, item.maxx);
        py            = clampc(item.cand_y[pick], item.miny, item.maxy);
        chosen_side   = {1'b0, pick};
        was_flipped   = found && (pick == (item.mode[1:0] ^ 2'd1));
        visible_share = {1'b1, {FRAC_BITS{1'b0}}};
        if (item.degen)
        begin
            px            = item.ax;
            py            = item.ay;
            chosen_side   = item.mode_raw;
            was_flipped   = 1'b0;
            visible_share = '0;
        end
        else if (item.mode == SIDE_POINT)
        begin
            px          = clampc(item.ax, item.minx, item.maxx);
            py          = clampc(item.ay, item.miny, item.maxy);
            chosen_side = SIDE_POINT;
            was_flipped = 1'b0;
        end

        ex = SW'(px);
        ey = SW'(py);
        if (ex > SAT_HI)
            ex = SAT_HI;
        else if (ex < SAT_LO)
            ex = SAT_LO;
        if (ey > SAT_HI)
            ey = SAT_HI;
        else if (ey < SAT_LO)
            ey = SAT_LO;
        place_x  = ex[COORD_BITS-1:0];
        place_y  = ey[COORD_BITS-1:0];
        fitted_w = item.fw;
        fitted_h = item.fh;
    end
endmodule
`default_nettype wire

// ===== src/popup_placement_selector_unit.sv =====
// Top level of the popup placement selector: front, classified-item queue, back, result queue.
// Depends on ppsu_pkg, ppsu_fifo, ppsu_front, ppsu_back and the assertion header.
`default_nettype none
// The unit accepts one anchor/popup item per cycle while full is low and returns one placement
// per item in order. An item is classified in the cycle of its transfer and waits in a two-entry
// queue; the back part selects the side combinationally and writes a two-entry result queue,
// so a result passes the item queue and then the result queue before it is on the result ports
// and can be taken with pop. The sustained rate is one item per cycle while results are popped
// and neither queue fills. Configuration writes are always ready; the registers are written
// at the clock edge and apply to items transferred after the write.
module popup_placement_selector_unit #(
    parameter int COORD_BITS = 21,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [20:0]             cfg_data,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic signed [20:0]      anchor_x,
    input  wire logic signed [20:0]      anchor_y,
    input  wire logic [19:0]             anchor_w,
    input  wire logic [19:0]             anchor_h,
    input  wire logic [19:0]             popup_w,
    input  wire logic [19:0]             popup_h,
    output logic                         empty,
    input  wire logic                    pop,
    output logic signed [COORD_BITS-1:0] place_x,
    output logic signed [COORD_BITS-1:0] place_y,
    output logic [19:0]                  fitted_w,
    output logic [19:0]                  fitted_h,
    output logic [2:0]                   chosen_side,
    output logic [FRAC_BITS:0]           visible_share,
    output logic                         was_flipped
);
    import ppsu_pkg::*;
    `include "popup_placement_selector_unit_assert.svh"

    localparam int IT_W = $bits(ppsu_item_t);
    localparam int RW   = 2 * COORD_BITS + 40 + 3 + FRAC_BITS + 1 + 1;

    ppsu_item_t               front_item, back_item;
    logic [IT_W-1:0]          mid_rd;
    logic                     mid_empty, res_full;
    logic [2:0]               mode_cfg;
    logic signed [COORD_BITS-1:0] b_x, b_y;
    logic [19:0]              b_w, b_h;
    logic [2:0]               b_side;
    logic [FRAC_BITS:0]       b_share;
    logic                     b_flip, move;
    logic [RW-1:0]            res_wr, res_rd;

    assign cfg_ready = 1'b1;
    assign move      = !mid_empty && !res_full;
    assign back_item = ppsu_item_t'(mid_rd);

    ppsu_front u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .anchor_x(anchor_x), .anchor_y(anchor_y), .anchor_w(anchor_w),
        .anchor_h(anchor_h), .popup_w(popup_w), .popup_h(popup_h),
        .item(front_item), .mode_cfg(mode_cfg)
    );

    ppsu_fifo #(.WIDTH(IT_W), .DEPTH(2)) u_mid_q (
        .clk(clk), .rst_n(rst_n),
        .wr_en(push), .wr_data(front_item),
        .rd_en(move), .rd_data(mid_rd),
        .full(full), .empty(mid_empty)
    );

    ppsu_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .item(back_item),
        .place_x(b_x), .place_y(b_y), .fitted_w(b_w), .fitted_h(b_h),
        .chosen_side(b_side), .visible_share(b_share), .was_flipped(b_flip)
    );

    assign res_wr = {b_x, b_y, b_w, b_h, b_side, b_share, b_flip};

    ppsu_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
        .clk(clk), .rst_n(rst_n),
        .wr_en(move), .wr_data(res_wr),
        .rd_en(pop), .rd_data(res_rd),
        .full(res_full), .empty(empty)
    );

    assign {place_x, place_y, fitted_w, fitted_h, chosen_side, visible_share, was_flipped}
        = res_rd;

    `PPSU_ASSERT(a_share_two_values,
        !empty |-> (visible_share == '0 || visible_share == {1'b1, {FRAC_BITS{1'b0}}}))
    `PPSU_ASSERT(a_flip_needs_fit,
        (!empty && was_flipped) |-> (visible_share != '0 && chosen_side != SIDE_POINT))
    `PPSU_ASSERT(a_degenerate_share,
        (!empty && (fitted_w == '0 || fitted_h == '0)) |-> (visible_share == '0))
    `PPSU_ASSERT_NEXT(a_cfg_mode_taken,
        (cfg_valid && cfg_index == REG_MODE), (mode_cfg == $past(cfg_data[2:0])))
endmodule
`default_nettype wire

// ===== verif/tb_popup_placement_selector_unit.sv =====
// Self-checking testbench for the popup placement selector unit.
// It predicts each placement from the register settings and checks results in order.
// Depends on ppsu_pkg and popup_placement_selector_unit.
`timescale 1ns / 100ps
`default_nettype none

module tb_popup_placement_selector_unit;
    import ppsu_pkg::*;

    typedef struct {
        longint px;
        longint py;
        longint fw;
        longint fh;
        longint side;
        longint share;
        longint flip;
    } placement_t;

    class placement_scoreboard;
        placement_t pending[$];
        int mismatches;
        int failures;

        function void note_item(placement_t p);
            pending.push_back(p);
        endfunction

        function bit same(placement_t a, placement_t b);
            return (a.px == b.px) && (a.py == b.py) && (a.fw == b.fw) && (a.fh == b.fh)
                && (a.side == b.side) && (a.share == b.share) && (a.flip == b.flip);
        endfunction

        function void check_result(placement_t got);
            placement_t want;
            if (pending.size() == 0)
            begin
                failures++;
                $display("Result with no expected placement waiting.");
                return;
            end
            want = pending.pop_front();
            if (!same(want, got))
            begin
                mismatches++;
                failures++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected x=%0d y=%0d w=%0d h=%0d side=%0d share=%0d",
                              " flip=%0d, got x=%0d y=%0d w=%0d h=%0d side=%0d share=%0d",
                              " flip=%0d"},
                        want.px, want.py, want.fw, want.fh, want.side, want.share, want.flip,
                        got.px, got.py, got.fw, got.fh, got.side, got.share, got.flip);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [20:0] cfg_data = '0;
    logic push = 1'b0;
    logic full;
    logic signed [20:0] anchor_x = '0;
    logic signed [20:0] anchor_y = '0;
    logic [19:0] anchor_w = '0;
    logic [19:0] anchor_h = '0;
    logic [19:0] popup_w = '0;
    logic [19:0] popup_h = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [20:0] place_x;
    logic signed [20:0] place_y;
    logic [19:0] fitted_w;
    logic [19:0] fitted_h;
    logic [2:0] chosen_side;
    logic [16:0] visible_share;
    logic was_flipped;

    longint vp_x, vp_y, vp_w, vp_h, margin, gap;
    int unsigned mode_reg;
    placement_scoreboard board;
    int idle_cycles = 0;
    bit stim_done;
    int pop_phase = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    popup_placement_selector_unit u_top (.*);

    function automatic longint clamp_l(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint max_l(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint min_l(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint share_of(longint x, longint y, longint w, longint h,
                                        longint vx, longint vy, longint vw, longint vh);
        longint area, iw, ih, inter, r, q;
        area = w * h;
        q = 0;
        if (area == 0) return 0;
        iw = max_l(0, min_l(x + w, vx + vw) - max_l(x, vx));
        ih = max_l(0, min_l(y + h, vy + vh) - max_l(y, vy));
        inter = iw * ih;
        if (inter >= area) return 65536;
        r = inter;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= area)
            begin
                r -= area;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic int side_at(int unsigned md, int k);
        int ord[4][4];
        ord = '{'{0, 1, 2, 3}, '{1, 0, 2, 3}, '{2, 3, 0, 1}, '{3, 2, 0, 1}};
        return ord[md][k];
    endfunction

    function automatic placement_t predict_placement(longint ax, longint ay, longint aw,
                                                     longint ah, longint pw, longint ph);
        placement_t p;
        int unsigned md;
        bit ok, found, have;
        longint vx, vy, vw, vh, padw, padh, fw, fh, minx, miny, maxx, maxy;
        longint cx[4], cy[4];
        longint x, y, s;
        int d;
        md = (mode_reg > 4) ? 0 : mode_reg;
        ok = (vp_w > 0) && (vp_h > 0);
        vx = ok ? vp_x : 0;
        vy = ok ? vp_y : 0;
        vw = ok ? vp_w : 0;
        vh = ok ? vp_h : 0;
        padw = max_l(0, vw - 2 * margin);
        padh = max_l(0, vh - 2 * margin);
        fw = clamp_l(pw, 0, padw);
        fh = clamp_l(ph, 0, padh);
        minx = vx + margin;
        miny = vy + margin;
        maxx = max_l(minx, vx + vw - margin - fw);
        maxy = max_l(miny, vy + vh - margin - fh);
        p.px = ax;
        p.py = ay;
        p.share = 0;
        p.side = md;
        p.flip = 0;
        if (ok && fw > 0 && fh > 0)
        begin
            if (md == 4)
            begin
                p.px = clamp_l(ax, minx, maxx);
                p.py = clamp_l(ay, miny, maxy);
                p.share = share_of(p.px, p.py, fw, fh, vx, vy, vw, vh);
            end
            else
            begin
                found = 0;
                for (int k = 0; k < 4; k++)
                begin
                    d = side_at(md, k);
                    case (d)
                        0: begin x = ax; y = ay + ah + gap; end
                        1: begin x = ax; y = ay - fh - gap; end
                        2: begin x = ax + aw + gap; y = ay; end
                        default: begin x = ax - fw - gap; y = ay; end
                    endcase
                    cx[k] = x;
                    cy[k] = y;
                    if (!found)
                    begin
                        if (d < 2) x = clamp_l(x, minx, maxx);
                        else y = clamp_l(y, miny, maxy);
                        if (x >= minx && y >= miny && x + fw <= minx + padw
                            && y + fh <= miny + padh)
                        begin
                            found = 1;
                            p.px = x;
                            p.py = y;
                            p.side = d;
                            p.share = 65536;
                        end
                    end
                end
                if (!found)
                begin
                    have = 0;
                    for (int k = 0; k < 4; k++)
                    begin
                        x = clamp_l(cx[k], minx, maxx);
                        y = clamp_l(cy[k], miny, maxy);
                        s = share_of(x, y, fw, fh, vx, vy, vw, vh);
                        if (!have || s > p.share)
                        begin
                            have = 1;
                            p.share = s;
                            p.px = x;
                            p.py = y;
                            p.side = side_at(md, k);
                        end
                    end
                end
                p.flip = (p.side == (md ^ 1)) ? 1 : 0;
            end
        end
        else
            p.side = mode_reg;
        p.px = clamp_l(p.px, -1048576, 1048575);
        p.py = clamp_l(p.py, -1048576, 1048575);
        p.fw = fw;
        p.fh = fh;
        return p;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [20:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_VP_X: vp_x = $signed(val);
            REG_VP_Y: vp_y = $signed(val);
            REG_VP_W: vp_w = val[19:0];
            REG_VP_H: vp_h = val[19:0];
            REG_MARGIN: margin = val[15:0];
            REG_GAP: gap = $signed(val[16:0]);
            REG_MODE: mode_reg = val[2:0];
            default: ;
        endcase
    endtask

    task automatic write_setup(logic [20:0] x, logic [20:0] y, logic [19:0] w,
                               logic [19:0] h, logic [15:0] m, logic [16:0] g,
                               logic [2:0] md);
        write_reg(REG_VP_X, x);
        write_reg(REG_VP_Y, y);
        write_reg(REG_VP_W, {1'b0, w});
        write_reg(REG_VP_H, {1'b0, h});
        write_reg(REG_MARGIN, {5'b0, m});
        write_reg(REG_GAP, {4'b0, g});
        write_reg(REG_MODE, {18'b0, md});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic [20:0] ax, logic [20:0] ay, logic [19:0] aw,
                             logic [19:0] ah, logic [19:0] pw, logic [19:0] ph);
        push <= 1'b1;
        anchor_x <= ax;
        anchor_y <= ay;
        anchor_w <= aw;
        anchor_h <= ah;
        popup_w <= pw;
        popup_h <= ph;
        do @(posedge clk); while (full);
        board.note_item(predict_placement($signed(ax), $signed(ay), aw, ah, pw, ph));
    endtask

    task automatic pause_push();
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(21'($urandom), 21'($urandom), 20'($urandom), 20'($urandom),
                              20'($urandom), 20'($urandom));
                else
                    send_item(21'(vp_x + $signed($urandom_range(0, 4000)) - 1000),
                              21'(vp_y + $signed($urandom_range(0, 4000)) - 1000),
                              20'($urandom_range(0, 600)), 20'($urandom_range(0, 600)),
                              20'($urandom_range(0, 2500)), 20'($urandom_range(0, 2500)));
                n++;
            end
            if ($urandom_range(0, 2) != 0)
                pause_push();
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            board.check_result('{place_x, place_y, fitted_w, fitted_h, chosen_side,
                                 visible_share, was_flipped});
        pop_phase <= pop_phase + 1;
        if (pop_phase % 64 < 20)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000 && !stim_done)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        board = new();
        stim_done = 0;
        vp_x = 0; vp_y = 0; vp_w = 0; vp_h = 0; margin = 0; gap = 0; mode_reg = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(0, 0, 10, 10, 100, 100);
        send_item(21'h100000, 21'h0FFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        drain();
        write_setup(0, 0, 3200, 2400, 16, 8, SIDE_BOTTOM);
        send_item(100, 100, 200, 50, 500, 300);
        send_item(100, 2300, 200, 50, 500, 300);
        send_item(0, 0, 0, 0, 0, 300);
        send_item(21'h0FFFFF, 21'h100000, 20'hFFFFF, 0, 20'hFFFFF, 20'hFFFFF);
        send_item(1500, 1100, 100, 100, 3100, 2300);
        drain();
        for (int md = 0; md < 8; md++)
        begin
            write_reg(REG_MODE, 21'(md));
            cfg_valid <= 1'b0;
            send_item(10, 10, 100, 100, 400, 400);
            send_item(3000, 2200, 100, 100, 400, 400);
            send_item(1400, 1000, 400, 400, 1500, 1100);
            drain();
        end
        write_setup(21'h100000, 21'h0FFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF,
                    17'h10000, SIDE_POINT);
        send_item(0, 0, 10, 10, 100, 100);
        drain();
        write_setup(21'h0FFFFF, 21'h100000, 20'hFFFFF, 20'hFFFFF, 0, 17'h0FFFF, SIDE_TOP);
        send_item(21'h0FFFFF, 21'h100000, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        send_item(21'h100000, 21'h0FFFFF, 0, 0, 1, 1);
        drain();

        for (int phase = 0; phase < 10; phase++)
        begin
            write_setup(21'($signed($urandom_range(0, 20000)) - 10000),
                        21'($signed($urandom_range(0, 20000)) - 10000),
                        20'((phase == 3) ? 0 : $urandom_range(1, 4000)),
                        20'($urandom_range(1, 4000)), 16'($urandom_range(0, 300)),
                        17'($signed($urandom_range(0, 200)) - 100),
                        3'((phase < 5) ? phase : $urandom_range(0, 7)));
            send_random(200);
        end
        stim_done = 1;
        if (board.failures == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/ppsu_pkg.sv
src/ppsu_fifo.sv
src/ppsu_front.sv
src/ppsu_back.sv
src/popup_placement_selector_unit.sv
verif/tb_popup_placement_selector_unit.sv
